// ===== sv/wps_pkg.sv =====
// Package: shared constants, types and the run table for the wipe pass generator.
`default_nettype none
package wps_pkg;
	localparam int MaxPasses = 53;
	localparam int TableLen = 53;
	localparam int RandDepth = 51;

	typedef logic [13:0] entry_t;

	// Run table, 16-bit two's complement words.
	function automatic logic [15:0] run_word(input logic [5:0] i);
		logic [15:0] w;
		begin
			case (i)
				6'd0: w = 16'hFFFE;
				6'd1: w = 16'd2;  6'd2: w = 16'h000; 6'd3: w = 16'hfff;
				6'd4: w = 16'd2;  6'd5: w = 16'h555; 6'd6: w = 16'haaa;
				6'd7: w = 16'hFFFF;
				6'd8: w = 16'd6;  6'd9: w = 16'h249; 6'd10: w = 16'h492;
				6'd11: w = 16'h6DB; 6'd12: w = 16'h924; 6'd13: w = 16'hB6D;
				6'd14: w = 16'hDB6;
				6'd15: w = 16'd12; 6'd16: w = 16'h111; 6'd17: w = 16'h222;
				6'd18: w = 16'h333; 6'd19: w = 16'h444; 6'd20: w = 16'h666;
				6'd21: w = 16'h777; 6'd22: w = 16'h888; 6'd23: w = 16'h999;
				6'd24: w = 16'hBBB; 6'd25: w = 16'hCCC; 6'd26: w = 16'hDDD;
				6'd27: w = 16'hEEE;
				6'd28: w = 16'd8;  6'd29: w = 16'h1000; 6'd30: w = 16'h1249;
				6'd31: w = 16'h1492; 6'd32: w = 16'h16DB; 6'd33: w = 16'h1924;
				6'd34: w = 16'h1B6D; 6'd35: w = 16'h1DB6; 6'd36: w = 16'h1FFF;
				6'd37: w = 16'd14; 6'd38: w = 16'h1111; 6'd39: w = 16'h1222;
				6'd40: w = 16'h1333; 6'd41: w = 16'h1444; 6'd42: w = 16'h1555;
				6'd43: w = 16'h1666; 6'd44: w = 16'h1777; 6'd45: w = 16'h1888;
				6'd46: w = 16'h1999; 6'd47: w = 16'h1AAA; 6'd48: w = 16'h1BBB;
				6'd49: w = 16'h1CCC; 6'd50: w = 16'h1DDD; 6'd51: w = 16'h1EEE;
				6'd52: w = 16'hFFFF;
				default: w = 16'h0000;
			endcase
			return w;
		end
	endfunction

	// Sequencer states
	typedef enum logic [11:0] {
		ST_LOAD  = 12'b000000000001,
		ST_FILL  = 12'b000000000010,
		ST_WALK  = 12'b000000000100,
		ST_SBYTE = 12'b000000001000,
		ST_SMOD  = 12'b000000010000,
		ST_SRDA  = 12'b000000100000,
		ST_SRDB  = 12'b000001000000,
		ST_SWR   = 12'b000010000000,
		ST_FXRD  = 12'b000100000000,
		ST_FXCHK = 12'b001000000000,
		ST_EMRD  = 12'b010000000000,
		ST_EMIT  = 12'b100000000000
	} state_t;
endpackage
`default_nettype wire

// ===== sv/wipe_pass_sequence_generator.sv =====
// Top level: wipe pass sequence generator with load, build, shuffle and emit sequencer.
// Usage: random bytes arrive on the input channel (random_byte, last_byte), one
// per beat. The beat with last_byte=1 is stored too while the 51-byte store has
// room and starts generation; in_stall stays high until every pass has been emitted.
// Generation: every pass position is preset as a random pass, then the run table
// is walked word by word (run headers, skips and wraps), then each shuffled
// position takes a store read, a byte fetch, the 8-step remainder unit and its
// done strobe, plus a partner read and write when it swaps; the shuffle decision
// and final exchange check follow; each emitted pass takes a store read and a beat.
// The pass store is a 53x14 memory with one registered read port, so every store
// access above is a registered read. pass_count is clamped to 53; zero emits nothing.
// Results leave as beats on out_valid/out_stall; a stalled beat holds and the
// sequencer waits in place. Reset clears the byte count and the sequencer;
// registers go to 35/1. Configuration is written on cfg_we with cfg_index and
// cfg_data; the user must do so only while idle, as the block does not enforce it.
`default_nettype none
module wipe_pass_sequence_generator
	import wps_pkg::*;
#(
	parameter int MAX_PASSES = MaxPasses
)(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] random_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            is_random_pass,
	output logic [12:0]     pattern_word,
	output logic [5:0]      pass_number,
	output logic            last_pass
);
	localparam logic [5:0] MaxP = 6'(MAX_PASSES);

	state_t     state_q;
	logic [6:0] pass_count_q;
	logic       shuffle_q;
	logic [5:0] n_q;
	logic [7:0] rnd_mem [RandDepth];
	logic [5:0] loaded_q;
	logic [13:0] pmem [MAX_PASSES];
	logic [13:0] rd_q;
	logic [5:0] p_q;
	logic [5:0] idx_q;
	logic [6:0] tgt_q;
	logic [6:0] left_q;
	logic [5:0] cnt_q;
	logic       inrun_q;
	logic [5:0] d_q;
	logic [13:0] ea_q;
	logic [7:0] byte_q;
	logic       m_start;
	logic       m_done;
	logic [5:0] m_rem;
	logic [15:0] w;
	logic [6:0] neg;
	logic [5:0] n_eff;
	logic       fix_q;
	logic [13:0] fixv_q;
	logic [13:0] emit_e;

	assign n_eff = (pass_count_q > 7'(MaxP)) ? MaxP : pass_count_q[5:0];
	assign w = run_word(idx_q);
	assign neg = 7'(-w);

	wps_modn u_mod (
		.clk(clk), .arst_n(arst_n), .start(m_start), .dividend(byte_q),
		.divisor(n_q), .done(m_done), .remainder(m_rem)
	);
	assign m_start = (state_q == ST_SBYTE);

	// emitted entry with the final exchange applied
	assign emit_e = (fix_q && p_q == 6'd1) ? fixv_q :
		(fix_q && p_q == n_q - 6'd1) ? 14'h2000 : rd_q;

	assign in_stall = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign is_random_pass = emit_e[13];
	assign pattern_word = emit_e[13] ? 13'd0 : emit_e[12:0];
	assign pass_number = p_q;
	assign last_pass = (p_q == n_q - 6'd1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q <= 7'd35;
			shuffle_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0)
				pass_count_q <= cfg_data;
			else
				shuffle_q <= cfg_data[0];
		end
	end

	// byte store (missing bytes read as zero through loaded_q)
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_valid && loaded_q < 6'(RandDepth))
			rnd_mem[loaded_q] <= random_byte;
		if (state_q == ST_SMOD)
			byte_q <= (p_q - 6'd2 < loaded_q) ? rnd_mem[p_q - 6'd2] : 8'd0;
	end

	// pass store: single write, registered read (old data on a same-address write)
	logic        we;
	logic [5:0]  wa;
	logic [13:0] wd;
	logic [5:0]  ra;
	always_comb begin
		we = 1'b0; wa = p_q; wd = 14'h2000; ra = p_q;
		unique case (state_q)
			ST_FILL: we = 1'b1;
			ST_WALK: begin
				wa = tgt_q[5:0];
				wd = {1'b0, w[12:0]};
				we = inrun_q && tgt_q < {1'b0, n_q} && idx_q < 6'(TableLen);
			end
			ST_SMOD: ra = p_q;
			ST_SRDB: begin ra = d_q; we = 1'b1; wa = d_q; wd = ea_q; end
			ST_SWR: begin we = 1'b1; wa = p_q; wd = rd_q; end
			ST_FXRD: ra = n_q - 6'd1;
			ST_FXCHK: begin
				ra = 6'd1;
			end
			ST_EMRD: ra = p_q;
			default: ;
		endcase
	end
	always_ff @(posedge clk) begin
		if (we)
			pmem[wa] <= wd;
		rd_q <= pmem[ra];
	end

	// sequencer
	logic fx_flag_q;
	logic [13:0] last_e_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			loaded_q <= '0;
			p_q <= '0;
			fx_flag_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: if (in_valid) begin
					if (last_byte && n_eff == 6'd0)
						loaded_q <= '0;
					else if (loaded_q < 6'(RandDepth))
						loaded_q <= loaded_q + 6'd1;
					if (last_byte) begin
						n_q <= n_eff;
						p_q <= '0;
						state_q <= (n_eff == 6'd0) ? ST_LOAD : ST_FILL;
					end
				end
				ST_FILL: begin
					p_q <= p_q + 6'd1;
					if (p_q == n_q - 6'd1) begin
						state_q <= ST_WALK;
						idx_q <= '0; tgt_q <= '0; left_q <= {1'b0, n_q};
						inrun_q <= 1'b0; cnt_q <= '0;
					end
				end
				ST_WALK: begin
					if (inrun_q) begin
						tgt_q <= tgt_q + 7'd1;
						idx_q <= (idx_q == 6'(TableLen)) ? idx_q : idx_q + 6'd1;
						cnt_q <= cnt_q - 6'd1;
						if (cnt_q == 6'd1) begin
							inrun_q <= 1'b0;
							if (left_q == 7'd0)
								state_q <= ST_FXRD;
						end
					end else if (left_q == 7'd0) begin
						state_q <= ST_FXRD;
					end else if (idx_q >= 6'(TableLen)) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 6'd1;
						if (w[15]) begin
							tgt_q <= tgt_q + neg;
							left_q <= (left_q > neg) ? left_q - neg : 7'd0;
							if (left_q <= neg)
								state_q <= ST_FXRD;
						end else if (w[6:0] != 7'd0) begin
							cnt_q <= (w[6:0] > left_q) ? left_q[5:0] : w[5:0];
							left_q <= (w[6:0] > left_q) ? 7'd0 : left_q - w[6:0];
							inrun_q <= 1'b1;
						end
					end
					p_q <= 6'd2;
				end
				ST_FXRD: begin
					// first pass here after walk: decide shuffle
					if (!fx_flag_q && n_q > 6'd2 && shuffle_q) begin
						fx_flag_q <= 1'b1;
						state_q <= ST_SMOD;
						p_q <= 6'd2;
					end else if (n_q > 6'd2) begin
						fx_flag_q <= 1'b0;
						state_q <= ST_FXCHK;
					end else begin
						fx_flag_q <= 1'b0;
						p_q <= '0;
						state_q <= ST_EMRD;
					end
				end
				ST_SMOD: state_q <= ST_SBYTE;
				ST_SBYTE: begin
					ea_q <= rd_q;
					state_q <= ST_SRDA;
				end
				// wait for the partner index, swap only when it is above 1
				ST_SRDA: if (m_done) begin
					d_q <= m_rem;
					if (m_rem > 6'd1)
						state_q <= ST_SRDB;
					else begin
						p_q <= p_q + 6'd1;
						state_q <= (p_q == n_q - 6'd1) ? ST_FXRD : ST_SMOD;
					end
				end
				ST_SRDB: state_q <= ST_SWR;
				ST_SWR: begin
					p_q <= p_q + 6'd1;
					state_q <= (p_q == n_q - 6'd1) ? ST_FXRD : ST_SMOD;
				end
				ST_FXCHK: begin
					if (!fx_flag_q) begin
						last_e_q <= rd_q;
						fx_flag_q <= 1'b1;
					end else begin
						fx_flag_q <= 1'b0;
						p_q <= '0;
						state_q <= ST_EMRD;
					end
				end
				ST_EMRD: state_q <= ST_EMIT;
				ST_EMIT: if (!out_stall) begin
					p_q <= p_q + 6'd1;
					if (p_q == n_q - 6'd1) begin
						state_q <= ST_LOAD;
						loaded_q <= '0;
					end else
						state_q <= ST_EMRD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// final exchange: applied on the emitted beats of pass 1 and the last pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fix_q <= 1'b0;
		else if (state_q == ST_FXCHK && fx_flag_q)
			fix_q <= !last_e_q[13] && rd_q[13];
		else if (state_q == ST_LOAD)
			fix_q <= 1'b0;
	end
	always_ff @(posedge clk)
		if (state_q == ST_FXCHK && fx_flag_q)
			fixv_q <= last_e_q;

	// protocol checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(is_random_pass)
			&& $stable(pattern_word) && $stable(pass_number) && $stable(last_pass));
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall));
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pass_number < n_q);
endmodule
`default_nettype wire

// ===== sv/wps_modn.sv =====
// Module: serial remainder unit, one restoring step per cycle.
`default_nettype none
module wps_modn
	import wps_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [7:0] dividend,
	input  wire logic [5:0] divisor,
	output logic            done,
	output logic [5:0]      remainder
);
	logic [7:0] rem_q;
	logic [7:0] quo_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic       done_q;
	logic [8:0] trial;

	assign trial = {rem_q, quo_q[7]} - {3'd0, divisor};

	// shift in one dividend bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= 4'd8;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			quo_q <= {quo_q[6:0], 1'b0};
			if (!trial[8])
				rem_q <= trial[7:0];
			else
				rem_q <= {rem_q[6:0], quo_q[7]};
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else
			done_q <= 1'b0;
	end

	// remainder is valid for the one cycle that done is high
	assign done = done_q;
	assign remainder = rem_q[5:0];
endmodule
`default_nettype wire
